@@ src/gbc_pkg.sv @@
// Shared constants, types and helpers for the gaze bilinear correction block.
`timescale 1ns / 1ps
package gbc_pkg;

   localparam int GAZE_BITS   = 15;
   localparam int LOAD_BITS   = 12;
   localparam int OUT_BITS    = 12;
   localparam int POINT_BITS  = 4;
   localparam int FRAC_BITS   = 14;
   localparam int WEIGHT_BITS = 28;
   localparam int WIDE_BITS   = 32;
   localparam int BANKS       = 4;
   localparam int BANK_DEPTH  = 8;

   localparam logic [GAZE_BITS-1:0] FULL_SCALE = 15'd25600;
   localparam logic [GAZE_BITS-1:0] CELL_SPAN  = 15'd12800;

   // 163840000 = 2^18 * 625; the 625 part uses a reciprocal multiply
   localparam int WEIGHT_SHIFT = 18;
   localparam int RECIP_BITS   = 27;
   localparam int RECIP_SHIFT  = 36;
   localparam logic [RECIP_BITS-1:0] RECIP_MULT = 27'd109951163;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       ok;
      logic [1:0] row;
      logic [1:0] col;
   } grid_pos_type;

   function automatic grid_pos_type point_pos(input logic [POINT_BITS-1:0] pt);
      grid_pos_type pos;
      pos = '0;
      unique case (pt)
         4'd0: pos = '{ok: 1'b1, row: 2'd0, col: 2'd0};
         4'd1: pos = '{ok: 1'b1, row: 2'd0, col: 2'd1};
         4'd2: pos = '{ok: 1'b1, row: 2'd0, col: 2'd2};
         4'd3: pos = '{ok: 1'b1, row: 2'd1, col: 2'd0};
         4'd4: pos = '{ok: 1'b1, row: 2'd1, col: 2'd1};
         4'd5: pos = '{ok: 1'b1, row: 2'd1, col: 2'd2};
         4'd6: pos = '{ok: 1'b1, row: 2'd2, col: 2'd0};
         4'd7: pos = '{ok: 1'b1, row: 2'd2, col: 2'd1};
         4'd8: pos = '{ok: 1'b1, row: 2'd2, col: 2'd2};
         default: pos = '{ok: 1'b0, row: 2'd0, col: 2'd0};
      endcase
      return pos;
   endfunction

endpackage

@@ src/gbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gbc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/gaze_bilinear_correction_top.sv @@
// Gaze bilinear correction: top level with banked grid tables and interpolation pipeline.
// Each item passes stage 1 (table read), stages 2 to 5 and then the output register.
// Throughput: one item per cycle while the output is not stalled; the four grid corners
// come from four RAM banks (split by row and column parity), each read once per query.
// Stages hold independently, so bubbles collapse under output stall.
// Reset clears pipeline valids only; grid tables are undefined until loaded.
`timescale 1ns / 1ps
module gaze_bilinear_correction_top #(
   parameter int PULSE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic                              req_eye_select,
   input  logic [gbc_pkg::POINT_BITS-1:0]    req_point_index,
   input  logic [gbc_pkg::LOAD_BITS-1:0]     req_load_lr,
   input  logic [gbc_pkg::LOAD_BITS-1:0]     req_load_ud,
   input  logic [gbc_pkg::GAZE_BITS-1:0]     req_gaze_x,
   input  logic [gbc_pkg::GAZE_BITS-1:0]     req_gaze_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gbc_pkg::OUT_BITS-1:0]      rsp_lr_pulse,
   output logic [gbc_pkg::OUT_BITS-1:0]      rsp_ud_pulse
);

   import gbc_pkg::*;

   localparam int ENTRY_BITS = 2 * PULSE_BITS;
   localparam int PROD_BITS  = WEIGHT_BITS + PULSE_BITS;
   localparam int NUM_BITS   = PROD_BITS - WEIGHT_SHIFT;
   localparam int QPROD_BITS = NUM_BITS + RECIP_BITS;
   localparam int ADDR_BITS  = $clog2(BANK_DEPTH);

   // handshake and stage enables
   logic en1, en2, en3, en4, en5, en6;
   logic accept, query_in;
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, rsp_valid_ff;
   logic s1_vld_in;

   assign en6       = !rsp_valid_ff || !rsp_stall;
   assign en5       = !s5_vld_ff || en6;
   assign en4       = !s4_vld_ff || en5;
   assign en3       = !s3_vld_ff || en4;
   assign en2       = !s2_vld_ff || en3;
   assign en1       = !s1_vld_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign query_in  = (req_type == REQ_QUERY);
   assign s1_vld_in = accept;

   // load path
   grid_pos_type          pos;
   logic [WIDE_BITS-1:0]  lr_wide, ud_wide;
   logic [BANKS-1:0]      bank_wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;

   assign pos     = point_pos(req_point_index);
   assign lr_wide = WIDE_BITS'(req_load_lr);
   assign ud_wide = WIDE_BITS'(req_load_ud);
   assign wr_addr = {req_eye_select, pos.row[1], pos.col[1]};
   assign wr_data = {ud_wide[PULSE_BITS-1:0], lr_wide[PULSE_BITS-1:0]};

   // query front end: clamp, invert y, cell and fraction
   logic [GAZE_BITS-1:0] gx, gy_c, gy, gx_sub, gy_sub;
   logic                 c0, r0;
   logic [FRAC_BITS-1:0] tx, ty;

   assign gx     = (req_gaze_x > FULL_SCALE) ? FULL_SCALE : req_gaze_x;
   assign gy_c   = (req_gaze_y > FULL_SCALE) ? FULL_SCALE : req_gaze_y;
   assign gy     = FULL_SCALE - gy_c;
   assign c0     = (gx >= CELL_SPAN);
   assign r0     = (gy >= CELL_SPAN);
   assign gx_sub = gx - (c0 ? CELL_SPAN : '0);
   assign gy_sub = gy - (r0 ? CELL_SPAN : '0);
   assign tx     = gx_sub[FRAC_BITS-1:0];
   assign ty     = gy_sub[FRAC_BITS-1:0];

   logic [ENTRY_BITS-1:0] bank_rd [BANKS];

   genvar g;
   generate
      for (g = 0; g < BANKS; g++) begin : g_bank
         localparam logic [1:0] PAR = 2'(g);
         logic [ADDR_BITS-1:0] rd_addr;

         assign bank_wr_en[g] = accept && !query_in && pos.ok &&
                                ({pos.row[0], pos.col[0]} == PAR);
         assign rd_addr = {req_eye_select, r0 & ~PAR[1], c0 & ~PAR[0]};

         gbc_ram #(
            .WIDTH (ENTRY_BITS),
            .DEPTH (BANK_DEPTH)
         ) u_ram (
            .clock   (clock),
            .wr_en   (bank_wr_en[g]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (accept && query_in),
            .rd_addr (rd_addr),
            .rd_data (bank_rd[g])
         );
      end
   endgenerate

   // stage 1: table data arrives
   logic                 s1_query_ff, s1_r0_ff, s1_c0_ff;
   logic [FRAC_BITS-1:0] s1_tx_ff, s1_ty_ff;
   // stage 2: weights and corner values
   logic                   s2_query_ff;
   logic [WEIGHT_BITS-1:0] s2_w_ff   [BANKS];
   logic [ENTRY_BITS-1:0]  s2_ent_ff [BANKS];
   // stage 3: weighted products
   logic                 s3_query_ff;
   logic [PROD_BITS-1:0] s3_plr_ff [BANKS];
   logic [PROD_BITS-1:0] s3_pud_ff [BANKS];
   // stage 4: sums scaled by 2^-18
   logic                s4_query_ff;
   logic [NUM_BITS-1:0] s4_nlr_ff, s4_nud_ff;
   // stage 5: reciprocal products
   logic                  s5_query_ff;
   logic [QPROD_BITS-1:0] s5_qlr_ff, s5_qud_ff;
   // output register
   logic [OUT_BITS-1:0] rsp_lr_ff, rsp_ud_ff;

   logic [FRAC_BITS-1:0]   ux, uy;
   logic [WEIGHT_BITS-1:0] w_in [BANKS];
   logic [ENTRY_BITS-1:0]  ent_in [BANKS];
   logic [PROD_BITS-1:0]   sum_lr, sum_ud;
   logic [WIDE_BITS-1:0]   out_lr_wide, out_ud_wide;

   assign ux = FRAC_BITS'(CELL_SPAN) - s1_tx_ff;
   assign uy = FRAC_BITS'(CELL_SPAN) - s1_ty_ff;

   // corner k = {row step, column step}
   assign ent_in[0] = bank_rd[{s1_r0_ff,  s1_c0_ff}];
   assign ent_in[1] = bank_rd[{s1_r0_ff, ~s1_c0_ff}];
   assign ent_in[2] = bank_rd[{~s1_r0_ff,  s1_c0_ff}];
   assign ent_in[3] = bank_rd[{~s1_r0_ff, ~s1_c0_ff}];
   assign w_in[0]   = WEIGHT_BITS'(ux) * WEIGHT_BITS'(uy);
   assign w_in[1]   = WEIGHT_BITS'(s1_tx_ff) * WEIGHT_BITS'(uy);
   assign w_in[2]   = WEIGHT_BITS'(ux) * WEIGHT_BITS'(s1_ty_ff);
   assign w_in[3]   = WEIGHT_BITS'(s1_tx_ff) * WEIGHT_BITS'(s1_ty_ff);

   assign sum_lr = s3_plr_ff[0] + s3_plr_ff[1] + s3_plr_ff[2] + s3_plr_ff[3];
   assign sum_ud = s3_pud_ff[0] + s3_pud_ff[1] + s3_pud_ff[2] + s3_pud_ff[3];

   assign out_lr_wide = WIDE_BITS'(s5_qlr_ff[RECIP_SHIFT +: PULSE_BITS]);
   assign out_ud_wide = WIDE_BITS'(s5_qud_ff[RECIP_SHIFT +: PULSE_BITS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_vld_ff    <= s1_vld_in;
         if (en2) s2_vld_ff    <= s1_vld_ff;
         if (en3) s3_vld_ff    <= s2_vld_ff;
         if (en4) s4_vld_ff    <= s3_vld_ff;
         if (en5) s5_vld_ff    <= s4_vld_ff;
         if (en6) rsp_valid_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_query_ff <= query_in;
         s1_r0_ff    <= r0;
         s1_c0_ff    <= c0;
         s1_tx_ff    <= tx;
         s1_ty_ff    <= ty;
      end
      if (en2) begin
         s2_query_ff <= s1_query_ff;
         for (int k = 0; k < BANKS; k++) begin
            s2_w_ff[k]   <= w_in[k];
            s2_ent_ff[k] <= ent_in[k];
         end
      end
      if (en3) begin
         s3_query_ff <= s2_query_ff;
         for (int k = 0; k < BANKS; k++) begin
            s3_plr_ff[k] <= PROD_BITS'(s2_w_ff[k]) *
                            PROD_BITS'(s2_ent_ff[k][PULSE_BITS-1:0]);
            s3_pud_ff[k] <= PROD_BITS'(s2_w_ff[k]) *
                            PROD_BITS'(s2_ent_ff[k][ENTRY_BITS-1:PULSE_BITS]);
         end
      end
      if (en4) begin
         s4_query_ff <= s3_query_ff;
         s4_nlr_ff   <= sum_lr[PROD_BITS-1:WEIGHT_SHIFT];
         s4_nud_ff   <= sum_ud[PROD_BITS-1:WEIGHT_SHIFT];
      end
      if (en5) begin
         s5_query_ff <= s4_query_ff;
         s5_qlr_ff   <= QPROD_BITS'(s4_nlr_ff) * QPROD_BITS'(RECIP_MULT);
         s5_qud_ff   <= QPROD_BITS'(s4_nud_ff) * QPROD_BITS'(RECIP_MULT);
      end
      if (en6) begin
         rsp_lr_ff <= s5_query_ff ? out_lr_wide[OUT_BITS-1:0] : '0;
         rsp_ud_ff <= s5_query_ff ? out_ud_wide[OUT_BITS-1:0] : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lr_pulse = rsp_lr_ff;
   assign rsp_ud_pulse = rsp_ud_ff;

   // checks
   a_stall_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff)
      else $error("input stalled with empty first stage");

   a_single_bank_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(bank_wr_en))
      else $error("more than one bank written in a cycle");

   a_query_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && query_in) |=> (s1_vld_ff && s1_query_ff))
      else $error("accepted query missing from first stage");

   a_load_result_zero: assert property (@(posedge clock) disable iff (reset)
      $past(en6 && s5_vld_ff && !s5_query_ff) |->
         (rsp_lr_pulse == '0 && rsp_ud_pulse == '0))
      else $error("load transfer gave a nonzero result");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the gaze bilinear correction block.
`timescale 1ns / 1ps
module testbench;
   import gbc_pkg::*;

   localparam longint unsigned FULL_UNITS   = 25600;
   localparam longint unsigned CELL_UNITS   = 12800;
   localparam longint unsigned WEIGHT_TOTAL = 163840000;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int HOLD_START     = 400;
   localparam int HOLD_CYCLES    = 200;
   localparam int STEADY_FIRST   = 500;
   localparam int STEADY_LAST    = 700;
   localparam int DRAIN_CYCLES   = 24;

   typedef struct packed {
      logic [OUT_BITS-1:0] lr;
      logic [OUT_BITS-1:0] ud;
   } pulse_pair_type;

   class gaze_pulse_checker;
      logic [LOAD_BITS-1:0] grid [2][9][2];
      pulse_pair_type       pending_pulses [$];
      int fail_count;
      int loads, off_grid, queries, clamped, checked;

      function new();
         fail_count = 0;
         loads = 0;
         off_grid = 0;
         queries = 0;
         clamped = 0;
         checked = 0;
      endfunction

      task flag_error(input string msg);
         $display("MISMATCH: %s", msg);
         fail_count++;
      endtask

      function logic [OUT_BITS-1:0] blend_axis(input int eye, input int c0, input int r0,
                                               input longint unsigned tx,
                                               input longint unsigned ty, input int ax);
         longint unsigned v00, v10, v01, v11, ux, uy, total;
         v00 = grid[eye][r0 * 3 + c0][ax];
         v10 = grid[eye][r0 * 3 + c0 + 1][ax];
         v01 = grid[eye][(r0 + 1) * 3 + c0][ax];
         v11 = grid[eye][(r0 + 1) * 3 + c0 + 1][ax];
         ux = CELL_UNITS - tx;
         uy = CELL_UNITS - ty;
         total = ux * uy * v00 + tx * uy * v10 + ux * ty * v01 + tx * ty * v11;
         return OUT_BITS'(total / WEIGHT_TOTAL);
      endfunction

      function pulse_pair_type interpolate(input int eye, input logic [GAZE_BITS-1:0] gaze_x,
                                           input logic [GAZE_BITS-1:0] gaze_y);
         longint unsigned gx, gy, tx, ty;
         int c0, r0;
         pulse_pair_type res;
         gx = (gaze_x > FULL_UNITS) ? FULL_UNITS : gaze_x;
         gy = (gaze_y > FULL_UNITS) ? FULL_UNITS : gaze_y;
         gy = FULL_UNITS - gy;
         c0 = (gx / CELL_UNITS > 1) ? 1 : int'(gx / CELL_UNITS);
         r0 = (gy / CELL_UNITS > 1) ? 1 : int'(gy / CELL_UNITS);
         tx = gx - longint'(c0) * CELL_UNITS;
         ty = gy - longint'(r0) * CELL_UNITS;
         res.lr = blend_axis(eye, c0, r0, tx, ty, 0);
         res.ud = blend_axis(eye, c0, r0, tx, ty, 1);
         return res;
      endfunction

      function void note_request(input req_kind_type kind, input logic eye,
                                 input logic [POINT_BITS-1:0] pt,
                                 input logic [LOAD_BITS-1:0] lr, input logic [LOAD_BITS-1:0] ud,
                                 input logic [GAZE_BITS-1:0] gx,
                                 input logic [GAZE_BITS-1:0] gy);
         pulse_pair_type res;
         if (kind == REQ_LOAD) begin
            loads++;
            if (pt < 9) begin
               grid[eye][pt][0] = lr;
               grid[eye][pt][1] = ud;
            end else begin
               off_grid++;
            end
            res = '0;
         end else begin
            queries++;
            if (gx > FULL_UNITS || gy > FULL_UNITS) clamped++;
            res = interpolate(int'(eye), gx, gy);
         end
         pending_pulses.push_back(res);
      endfunction

      task check_response(input logic [OUT_BITS-1:0] lr, input logic [OUT_BITS-1:0] ud);
         pulse_pair_type exp_pair;
         if (pending_pulses.size() == 0) begin
            flag_error($sformatf("unexpected result lr=%0d ud=%0d", lr, ud));
         end else begin
            exp_pair = pending_pulses.pop_front();
            checked++;
            if (lr !== exp_pair.lr)
               flag_error($sformatf("lr_pulse got %0d want %0d", lr, exp_pair.lr));
            if (ud !== exp_pair.ud)
               flag_error($sformatf("ud_pulse got %0d want %0d", ud, exp_pair.ud));
         end
      endtask

      function int pending_count();
         return pending_pulses.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic req_type;
   logic req_eye_select;
   logic [POINT_BITS-1:0] req_point_index;
   logic [LOAD_BITS-1:0]  req_load_lr;
   logic [LOAD_BITS-1:0]  req_load_ud;
   logic [GAZE_BITS-1:0]  req_gaze_x;
   logic [GAZE_BITS-1:0]  req_gaze_y;
   logic rsp_valid;
   logic rsp_stall;
   logic [OUT_BITS-1:0] rsp_lr_pulse;
   logic [OUT_BITS-1:0] rsp_ud_pulse;
   logic steady_run;

   gaze_pulse_checker sb = new();

   gaze_bilinear_correction_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_eye_select  (req_eye_select),
      .req_point_index (req_point_index),
      .req_load_lr     (req_load_lr),
      .req_load_ud     (req_load_ud),
      .req_gaze_x      (req_gaze_x),
      .req_gaze_y      (req_gaze_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lr_pulse    (rsp_lr_pulse),
      .rsp_ud_pulse    (rsp_ud_pulse)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // transfer monitor on both channels
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_kind_type'(req_type), req_eye_select, req_point_index,
                            req_load_lr, req_load_ud, req_gaze_x, req_gaze_y);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_lr_pulse, rsp_ud_pulse);
      end
   end

   task automatic drive_item(input req_kind_type kind, input logic eye,
                             input logic [POINT_BITS-1:0] pt,
                             input logic [LOAD_BITS-1:0] lr, input logic [LOAD_BITS-1:0] ud,
                             input logic [GAZE_BITS-1:0] gx, input logic [GAZE_BITS-1:0] gy);
      int gap;
      gap = 0;
      while (!steady_run && $urandom_range(99) < 21) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_eye_select  <= eye;
      req_point_index <= pt;
      req_load_lr     <= lr;
      req_load_ud     <= ud;
      req_gaze_x      <= gx;
      req_gaze_y      <= gy;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [GAZE_BITS-1:0] pick_gaze();
      int mode;
      mode = $urandom_range(99);
      if (mode < 60) return GAZE_BITS'($urandom_range(25600));
      if (mode < 75) return GAZE_BITS'($urandom_range(32767));
      case ($urandom_range(7))
         0: return 15'd0;
         1: return 15'd12799;
         2: return 15'd12800;
         3: return 15'd12801;
         4: return 15'd25599;
         5: return 15'd25600;
         6: return 15'd25601;
         default: return 15'd32767;
      endcase
   endfunction

   function automatic logic [LOAD_BITS-1:0] pick_pulse();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return LOAD_BITS'($urandom_range(4095));
      endcase
   endfunction

   // result side: random stall, one long hold-off, no stall in the steady window
   initial begin
      int unsigned cyc;
      cyc = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         cyc++;
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) rsp_stall <= 1'b1;
         else if (steady_run) rsp_stall <= 1'b0;
         else rsp_stall <= ($urandom_range(99) < 21);
      end
   end

   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [LOAD_BITS-1:0] lr, ud;
      int idx;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_LOAD;
      req_eye_select  <= 1'b0;
      req_point_index <= '0;
      req_load_lr     <= '0;
      req_load_ud     <= '0;
      req_gaze_x      <= '0;
      req_gaze_y      <= '0;
      steady_run      <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill both grids, extremes at the first and last entry
      for (int e = 0; e < 2; e++) begin
         for (int p = 0; p < 9; p++) begin
            idx = e * 9 + p;
            lr = (idx == 0) ? 12'd0 : (idx == 17) ? 12'd4095 : pick_pulse();
            ud = (idx == 0) ? 12'd4095 : (idx == 17) ? 12'd0 : pick_pulse();
            drive_item(REQ_LOAD, e[0], p[3:0], lr, ud, pick_gaze(), pick_gaze());
         end
      end
      // off-grid point index is dropped
      drive_item(REQ_LOAD, 1'b1, 4'd15, 12'd4095, 12'd4095, 15'd0, 15'd0);
      drive_item(REQ_QUERY, 1'b0, 4'd0, 12'd0, 12'd0, 15'd0, 15'd0);
      drive_item(REQ_QUERY, 1'b1, 4'd15, 12'd4095, 12'd4095, 15'd32767, 15'd32767);
      drive_item(REQ_QUERY, 1'b0, 4'd0, 12'd0, 12'd0, 15'd25600, 15'd0);
      drive_item(REQ_QUERY, 1'b1, 4'd0, 12'd0, 12'd0, 15'd12800, 15'd12800);
      drive_item(REQ_QUERY, 1'b0, 4'd0, 12'd0, 12'd0, 15'd0, 15'd25600);
      drive_item(REQ_QUERY, 1'b1, 4'd0, 12'd0, 12'd0, 15'd25599, 15'd1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == STEADY_FIRST) steady_run <= 1'b1;
         else if (n == STEADY_LAST) steady_run <= 1'b0;
         if ($urandom_range(99) < 25)
            drive_item(REQ_LOAD, 1'($urandom_range(1)),
                       ($urandom_range(99) < 80) ? 4'($urandom_range(8))
                                                 : 4'($urandom_range(15, 9)),
                       pick_pulse(), pick_pulse(), 15'($urandom), 15'($urandom));
         else
            drive_item(REQ_QUERY, 1'($urandom_range(1)), 4'($urandom), 12'($urandom),
                       12'($urandom), pick_gaze(), pick_gaze());
      end
      req_valid <= 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d grid loads (%0d off-grid) and %0d gaze queries (%0d clamped),",
               sb.loads, sb.off_grid, sb.queries, sb.clamped);
      $display("with a long result hold-off; %0d results compared, %0d mismatches.",
               sb.checked, sb.fail_count);
      if (sb.fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
